@@ hdl/scalar_bias_kalman_estimator_defines.svh @@
// Assertion macros used by the checker file.
`ifndef SCALAR_BIAS_KALMAN_ESTIMATOR_DEFINES_SVH
`define SCALAR_BIAS_KALMAN_ESTIMATOR_DEFINES_SVH

// The consequent is checked in the same cycle as the antecedent.
`define SBKE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define SBKE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sbke_pkg.sv @@
package sbke_pkg;

    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_PROCESS_VARIANCE = 3'd0;
    localparam logic [2:0] REG_BOOST_GAIN       = 3'd1;
    localparam logic [2:0] REG_GATE_SIZE        = 3'd2;
    localparam logic [2:0] REG_BIAS_LIMIT       = 3'd3;
    localparam logic [2:0] REG_VARIANCE_LIMIT   = 3'd4;
    localparam logic [2:0] REG_MONITOR_TC       = 3'd5;
    localparam logic [2:0] REG_LPF_ALPHA        = 3'd6;

    localparam logic [30:0] PV_RESET         = 31'd1;
    localparam logic [30:0] BOOST_RESET      = 31'd65536;
    localparam logic [30:0] GATE_RESET       = 31'd196608;
    localparam logic [30:0] BIAS_LIMIT_RESET = 31'd6553600;
    localparam logic [30:0] VAR_LIMIT_RESET  = 31'd65536;
    localparam logic [30:0] MTC_RESET        = 31'd655360;
    localparam logic [16:0] ALPHA_RESET      = 17'd655;

    localparam logic [30:0] MAX31         = 31'h7FFF_FFFF;
    localparam logic [16:0] ONE_Q         = 17'd65536;
    localparam logic [32:0] LPF_THRESHOLD = 33'd13107;
    localparam logic [30:0] STEP_TOL      = 31'd65;
    localparam logic [6:0]  DIV_STEPS     = 7'd64;

    typedef struct packed {
        logic [30:0] process_variance;
        logic [30:0] boost_gain;
        logic [30:0] gate_size;
        logic [30:0] bias_limit;
        logic [30:0] variance_limit;
        logic [30:0] monitor_time_constant;
        logic [16:0] lpf_alpha;
    } t_cfg;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE       = 5'd0;
    localparam t_op OP_LOAD       = 5'd1;
    localparam t_op OP_SQ_DT      = 5'd2;
    localparam t_op OP_MUL_HI     = 5'd3;
    localparam t_op OP_MUL_LO     = 5'd4;
    localparam t_op OP_DELTA      = 5'd5;
    localparam t_op OP_MUL_BOOST  = 5'd6;
    localparam t_op OP_VAR_PRED   = 5'd7;
    localparam t_op OP_INNOV      = 5'd8;
    localparam t_op OP_DIV_T      = 5'd9;
    localparam t_op OP_T_STORE    = 5'd10;
    localparam t_op OP_SQ_T       = 5'd11;
    localparam t_op OP_DIV_PROD   = 5'd12;
    localparam t_op OP_RATIO_STORE = 5'd13;
    localparam t_op OP_MUL_GAIN   = 5'd14;
    localparam t_op OP_BIAS_UPD   = 5'd15;
    localparam t_op OP_SQ_VAR     = 5'd16;
    localparam t_op OP_VAR_UPD    = 5'd17;
    localparam t_op OP_FINISH     = 5'd18;
    localparam t_op OP_CAPTURE    = 5'd19;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic pass;
    } t_dp_status;

endpackage

@@ hdl/scalar_bias_kalman_estimator.sv @@
// One transaction is worked on at a time; each fuse runs two passes through the
// shared radix-2 divider, or four when the gate passes it, which sets its cost.
// Synchronous active-low reset restores register defaults and the initial filter state.
module scalar_bias_kalman_estimator import sbke_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [30:0]        i_time_step,
    input  logic signed [31:0] i_measurement,
    input  logic [30:0]        i_measurement_variance,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_bias,
    output logic [30:0]        o_bias_variance,
    output logic signed [31:0] o_innovation,
    output logic [30:0]        o_innovation_variance,
    output logic [30:0]        o_test_ratio,
    output logic               o_offset_detected,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg       r_cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.process_variance      <= PV_RESET;
            r_cfg.boost_gain            <= BOOST_RESET;
            r_cfg.gate_size             <= GATE_RESET;
            r_cfg.bias_limit            <= BIAS_LIMIT_RESET;
            r_cfg.variance_limit        <= VAR_LIMIT_RESET;
            r_cfg.monitor_time_constant <= MTC_RESET;
            r_cfg.lpf_alpha             <= ALPHA_RESET;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_PROCESS_VARIANCE: r_cfg.process_variance      <= pwdata[30:0];
                REG_BOOST_GAIN:       r_cfg.boost_gain            <= pwdata[30:0];
                REG_GATE_SIZE:        r_cfg.gate_size             <= pwdata[30:0];
                REG_BIAS_LIMIT:       r_cfg.bias_limit            <= pwdata[30:0];
                REG_VARIANCE_LIMIT:   r_cfg.variance_limit        <= pwdata[30:0];
                REG_MONITOR_TC:       r_cfg.monitor_time_constant <= pwdata[30:0];
                REG_LPF_ALPHA:        r_cfg.lpf_alpha             <= pwdata[16:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_PROCESS_VARIANCE: prdata = {1'b0, r_cfg.process_variance};
            REG_BOOST_GAIN:       prdata = {1'b0, r_cfg.boost_gain};
            REG_GATE_SIZE:        prdata = {1'b0, r_cfg.gate_size};
            REG_BIAS_LIMIT:       prdata = {1'b0, r_cfg.bias_limit};
            REG_VARIANCE_LIMIT:   prdata = {1'b0, r_cfg.variance_limit};
            REG_MONITOR_TC:       prdata = {1'b0, r_cfg.monitor_time_constant};
            REG_LPF_ALPHA:        prdata = {15'd0, r_cfg.lpf_alpha};
            default:              prdata = 32'd0;
        endcase
    end

    sbke_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    sbke_datapath u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg                  (r_cfg),
        .i_cmd                  (dp_cmd),
        .i_time_step            (i_time_step),
        .i_measurement          (i_measurement),
        .i_measurement_variance (i_measurement_variance),
        .o_status               (dp_status),
        .o_bias                 (o_bias),
        .o_bias_variance        (o_bias_variance),
        .o_innovation           (o_innovation),
        .o_innovation_variance  (o_innovation_variance),
        .o_test_ratio           (o_test_ratio),
        .o_offset_detected      (o_offset_detected)
    );

endmodule

@@ hdl/sbke_datapath.sv @@
module sbke_datapath import sbke_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    input  logic [30:0]        i_time_step,
    input  logic signed [31:0] i_measurement,
    input  logic [30:0]        i_measurement_variance,
    output t_dp_status         o_status,
    output logic signed [31:0] o_bias,
    output logic [30:0]        o_bias_variance,
    output logic signed [31:0] o_innovation,
    output logic [30:0]        o_innovation_variance,
    output logic [30:0]        o_test_ratio,
    output logic               o_offset_detected
);

    // Filter state.
    logic [31:0] r_bias, r_lpf, r_tpos, r_tneg, r_hinnov;
    logic [30:0] r_var, r_last, r_hivar, r_hratio;
    logic [6:0]  r_cnt;

    // Item operands and intermediate values.
    logic [30:0] r_dt, r_mvar;
    logic [31:0] r_meas;
    logic [65:0] r_prod;
    logic [61:0] r_acc;
    logic [31:0] r_d2lo;
    logic [30:0] r_delta;
    logic        r_boost_on;
    logic [32:0] r_innov, r_mag;
    logic [31:0] r_ivar, r_t;
    logic [30:0] r_ratio;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_dsr;

    // Result registers.
    logic [31:0] r_o_bias, r_o_innov;
    logic [30:0] r_o_var, r_o_ivar, r_o_ratio;
    logic        r_o_flag;

    function automatic logic [30:0] clamp_var(input logic [32:0] x, input logic [30:0] lim);
        logic [32:0] y;
        y = (x > {2'b00, lim}) ? {2'b00, lim} : x;
        if (y == 33'd0) begin
            y = 33'd1;
        end
        return y[30:0];
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [30:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {2'b00, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Shared multiplier.
    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_SQ_DT: begin
                mul_a = {2'b00, r_dt};
                mul_b = {2'b00, r_dt};
            end
            OP_MUL_HI: begin
                mul_a = {2'b00, i_cfg.process_variance};
                mul_b = {3'b000, r_prod[61:32]};
            end
            OP_MUL_LO: begin
                mul_a = {2'b00, i_cfg.process_variance};
                mul_b = {1'b0, r_d2lo};
            end
            OP_MUL_BOOST: begin
                mul_a = {2'b00, r_delta};
                mul_b = {2'b00, i_cfg.boost_gain};
            end
            OP_SQ_T: begin
                mul_a = {1'b0, r_t};
                mul_b = {1'b0, r_t};
            end
            OP_MUL_GAIN: begin
                mul_a = {2'b00, r_var};
                mul_b = r_mag;
            end
            OP_SQ_VAR: begin
                mul_a = {2'b00, r_var};
                mul_b = {2'b00, r_var};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Offset condition on the current state.
    logic [32:0] lpf_ext, lpf_abs;
    logic        flag;

    assign lpf_ext = {r_lpf[31], r_lpf};
    assign lpf_abs = r_lpf[31] ? (33'd0 - lpf_ext) : lpf_ext;
    assign flag    = (lpf_abs > LPF_THRESHOLD)
                  || (r_tpos > {1'b0, i_cfg.monitor_time_constant})
                  || (r_tneg > {1'b0, i_cfg.monitor_time_constant});

    // Restoring divider, one quotient bit per cycle.
    logic [32:0] rem_sh, rem_sub;
    logic        rem_ge;

    assign rem_sh  = {r_rem, r_quo[63]};
    assign rem_ge  = rem_sh >= {1'b0, r_dsr};
    assign rem_sub = rem_sh - {1'b0, r_dsr};

    // Predict arithmetic.
    logic [62:0] delta_sum;
    logic [30:0] delta_sat, boost_sat, pred_d, dt_diff;
    logic [32:0] var_sum;

    assign delta_sum = {1'b0, r_acc} + {29'd0, r_prod[65:32]};
    assign delta_sat = (|delta_sum[62:31]) ? MAX31 : delta_sum[30:0];
    assign boost_sat = (|r_prod[65:47]) ? MAX31 : r_prod[46:16];
    assign pred_d    = r_boost_on ? boost_sat : r_delta;
    assign var_sum   = {2'b00, r_var} + {2'b00, pred_d};
    assign dt_diff   = (r_dt > r_last) ? (r_dt - r_last) : (r_last - r_dt);

    // Fuse arithmetic.
    logic [32:0] innov_c, mag_c;
    logic [31:0] ivar_c, t_c;
    logic [30:0] ratio_c, var_dec;
    logic signed [34:0] bias_ext, m_ext, nb, lim_s;
    logic [31:0] bias_new;

    assign innov_c = {r_meas[31], r_meas} - {r_bias[31], r_bias};
    assign mag_c   = innov_c[32] ? (33'd0 - innov_c) : innov_c;
    assign ivar_c  = {1'b0, r_var} + {1'b0, r_mvar};

    always_comb begin
        if (i_cfg.gate_size == 31'd0) begin
            t_c = (|r_mag) ? 32'hFFFF_FFFF : 32'd0;
        end else begin
            t_c = (|r_quo[63:32]) ? 32'hFFFF_FFFF : r_quo[31:0];
        end
    end

    assign ratio_c  = (|r_quo[63:31]) ? MAX31 : r_quo[30:0];
    assign bias_ext = $signed({{3{r_bias[31]}}, r_bias});
    assign m_ext    = $signed({2'b00, r_quo[32:0]});
    assign lim_s    = $signed({4'b0000, i_cfg.bias_limit});
    assign nb       = r_innov[32] ? (bias_ext - m_ext) : (bias_ext + m_ext);

    always_comb begin
        if (nb > lim_s) begin
            bias_new = lim_s[31:0];
        end else if (nb < -lim_s) begin
            bias_new = 32'd0 - lim_s[31:0];
        end else begin
            bias_new = nb[31:0];
        end
    end

    assign var_dec = r_var - r_quo[30:0];

    // Low-pass of the signed, clamped test ratio; the product is floored.
    logic [16:0] ratio_cl, alpha_c;
    logic [33:0] x_mag;
    logic signed [33:0] x_s, diff_s;
    logic signed [51:0] lpf_prod;
    logic        innov_zero, innov_pos;

    assign innov_zero = (r_innov == 33'd0);
    assign innov_pos  = !r_innov[32] && !innov_zero;
    assign ratio_cl   = (r_ratio > {14'd0, ONE_Q}) ? ONE_Q : r_ratio[16:0];
    assign alpha_c    = (i_cfg.lpf_alpha > ONE_Q) ? ONE_Q : i_cfg.lpf_alpha;
    assign x_mag      = {17'd0, ratio_cl};
    assign x_s        = innov_zero ? 34'sd0
                      : (r_innov[32] ? $signed(34'd0 - x_mag) : $signed(x_mag));
    assign diff_s     = x_s - $signed({{2{r_lpf[31]}}, r_lpf});
    assign lpf_prod   = $signed({1'b0, alpha_c}) * diff_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias   <= '0;
            r_var    <= VAR_LIMIT_RESET;
            r_last   <= '0;
            r_lpf    <= '0;
            r_tpos   <= '0;
            r_tneg   <= '0;
            r_hinnov <= '0;
            r_hivar  <= '0;
            r_hratio <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
            end
            case (i_cmd.op)
                OP_DIV_T, OP_DIV_PROD: begin
                    r_cnt <= DIV_STEPS;
                end
                OP_VAR_PRED: begin
                    r_var <= clamp_var(var_sum, i_cfg.variance_limit);
                    if (r_dt != 31'd0 && dt_diff > STEP_TOL) begin
                        r_last <= r_dt;
                    end
                end
                OP_BIAS_UPD: begin
                    r_bias <= bias_new;
                end
                OP_VAR_UPD: begin
                    r_var <= clamp_var({2'b00, var_dec}, i_cfg.variance_limit);
                end
                OP_FINISH: begin
                    r_lpf <= r_lpf + lpf_prod[47:16];
                    if (innov_pos) begin
                        r_tpos <= '0;
                        r_tneg <= add_sat(r_tneg, r_last);
                    end else begin
                        r_tneg <= '0;
                        r_tpos <= add_sat(r_tpos, r_last);
                    end
                    if (!r_innov[32] && r_innov[31]) begin
                        r_hinnov <= 32'h7FFF_FFFF;
                    end else if (r_innov[32] && !r_innov[31]) begin
                        r_hinnov <= 32'h8000_0000;
                    end else begin
                        r_hinnov <= r_innov[31:0];
                    end
                    r_hivar  <= r_ivar[31] ? MAX31 : r_ivar[30:0];
                    r_hratio <= r_ratio;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt != 7'd0) begin
            r_rem <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
            r_quo <= {r_quo[62:0], rem_ge};
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_dt   <= i_time_step;
                r_meas <= i_measurement;
                r_mvar <= i_measurement_variance;
            end
            OP_SQ_DT, OP_SQ_T, OP_MUL_GAIN, OP_SQ_VAR: begin
                r_prod <= mul_p;
            end
            OP_MUL_HI: begin
                r_d2lo <= r_prod[31:0];
                r_prod <= mul_p;
            end
            OP_MUL_LO: begin
                r_acc  <= r_prod[61:0];
                r_prod <= mul_p;
            end
            OP_DELTA: begin
                r_delta <= delta_sat;
            end
            OP_MUL_BOOST: begin
                r_prod     <= mul_p;
                r_boost_on <= flag;
            end
            OP_INNOV: begin
                r_innov <= innov_c;
                r_mag   <= mag_c;
                r_ivar  <= ivar_c;
            end
            OP_DIV_T: begin
                r_rem <= '0;
                r_quo <= {15'd0, r_mag, 16'd0};
                r_dsr <= {1'b0, i_cfg.gate_size};
            end
            OP_DIV_PROD: begin
                r_rem <= '0;
                r_quo <= r_prod[63:0];
                r_dsr <= r_ivar;
            end
            OP_T_STORE: begin
                r_t <= t_c;
            end
            OP_RATIO_STORE: begin
                r_ratio <= ratio_c;
            end
            OP_CAPTURE: begin
                r_o_bias  <= r_bias;
                r_o_var   <= r_var;
                r_o_innov <= r_hinnov;
                r_o_ivar  <= r_hivar;
                r_o_ratio <= r_hratio;
                r_o_flag  <= flag;
            end
            default: begin
            end
        endcase
    end

    assign o_status.div_done = (r_cnt == 7'd0);
    assign o_status.pass     = (r_ratio < {14'd0, ONE_Q});

    assign o_bias                = r_o_bias;
    assign o_bias_variance       = r_o_var;
    assign o_innovation          = r_o_innov;
    assign o_innovation_variance = r_o_ivar;
    assign o_test_ratio          = r_o_ratio;
    assign o_offset_detected     = r_o_flag;

endmodule

@@ hdl/sbke_ctrl.sv @@
module sbke_ctrl import sbke_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_cmd,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall,
    output logic       o_out_valid
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_P_SQ    = 5'd1;
    localparam logic [4:0] S_P_HI    = 5'd2;
    localparam logic [4:0] S_P_LO    = 5'd3;
    localparam logic [4:0] S_P_DELTA = 5'd4;
    localparam logic [4:0] S_P_BOOST = 5'd5;
    localparam logic [4:0] S_P_VAR   = 5'd6;
    localparam logic [4:0] S_F_INNOV = 5'd7;
    localparam logic [4:0] S_F_DIVT  = 5'd8;
    localparam logic [4:0] S_F_WAITT = 5'd9;
    localparam logic [4:0] S_F_TSTO  = 5'd10;
    localparam logic [4:0] S_F_SQT   = 5'd11;
    localparam logic [4:0] S_F_DIVR  = 5'd12;
    localparam logic [4:0] S_F_WAITR = 5'd13;
    localparam logic [4:0] S_F_RSTO  = 5'd14;
    localparam logic [4:0] S_F_GAIN  = 5'd15;
    localparam logic [4:0] S_F_DIVG  = 5'd16;
    localparam logic [4:0] S_F_WAITG = 5'd17;
    localparam logic [4:0] S_F_BIAS  = 5'd18;
    localparam logic [4:0] S_F_SQV   = 5'd19;
    localparam logic [4:0] S_F_DIVV  = 5'd20;
    localparam logic [4:0] S_F_WAITV = 5'd21;
    localparam logic [4:0] S_F_VAR   = 5'd22;
    localparam logic [4:0] S_F_FIN   = 5'd23;
    localparam logic [4:0] S_OUT     = 5'd24;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = i_cmd ? S_F_INNOV : S_P_SQ;
                end
            end
            S_P_SQ: begin
                o_cmd.op = OP_SQ_DT;
                n_state  = S_P_HI;
            end
            S_P_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = S_P_LO;
            end
            S_P_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = S_P_DELTA;
            end
            S_P_DELTA: begin
                o_cmd.op = OP_DELTA;
                n_state  = S_P_BOOST;
            end
            S_P_BOOST: begin
                o_cmd.op = OP_MUL_BOOST;
                n_state  = S_P_VAR;
            end
            S_P_VAR: begin
                o_cmd.op = OP_VAR_PRED;
                n_state  = S_OUT;
            end
            S_F_INNOV: begin
                o_cmd.op = OP_INNOV;
                n_state  = S_F_DIVT;
            end
            S_F_DIVT: begin
                o_cmd.op = OP_DIV_T;
                n_state  = S_F_WAITT;
            end
            S_F_WAITT: begin
                if (i_status.div_done) begin
                    n_state = S_F_TSTO;
                end
            end
            S_F_TSTO: begin
                o_cmd.op = OP_T_STORE;
                n_state  = S_F_SQT;
            end
            S_F_SQT: begin
                o_cmd.op = OP_SQ_T;
                n_state  = S_F_DIVR;
            end
            S_F_DIVR: begin
                o_cmd.op = OP_DIV_PROD;
                n_state  = S_F_WAITR;
            end
            S_F_WAITR: begin
                if (i_status.div_done) begin
                    n_state = S_F_RSTO;
                end
            end
            S_F_RSTO: begin
                o_cmd.op = OP_RATIO_STORE;
                n_state  = S_F_GAIN;
            end
            S_F_GAIN: begin
                // A ratio outside the gate skips the measurement update.
                if (i_status.pass) begin
                    o_cmd.op = OP_MUL_GAIN;
                    n_state  = S_F_DIVG;
                end else begin
                    n_state = S_F_FIN;
                end
            end
            S_F_DIVG: begin
                o_cmd.op = OP_DIV_PROD;
                n_state  = S_F_WAITG;
            end
            S_F_WAITG: begin
                if (i_status.div_done) begin
                    n_state = S_F_BIAS;
                end
            end
            S_F_BIAS: begin
                o_cmd.op = OP_BIAS_UPD;
                n_state  = S_F_SQV;
            end
            S_F_SQV: begin
                o_cmd.op = OP_SQ_VAR;
                n_state  = S_F_DIVV;
            end
            S_F_DIVV: begin
                o_cmd.op = OP_DIV_PROD;
                n_state  = S_F_WAITV;
            end
            S_F_WAITV: begin
                if (i_status.div_done) begin
                    n_state = S_F_VAR;
                end
            end
            S_F_VAR: begin
                o_cmd.op = OP_VAR_UPD;
                n_state  = S_F_FIN;
            end
            S_F_FIN: begin
                o_cmd.op = OP_FINISH;
                n_state  = S_OUT;
            end
            S_OUT: begin
                // The result register is loaded once the previous transaction has left.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op    = OP_CAPTURE;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/sbke_checker.sv @@
`include "scalar_bias_kalman_estimator_defines.svh"

module sbke_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_bias,
    input logic [30:0] o_bias_variance
);

    // A stalled result transaction keeps its payload.
    `SBKE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_bias), "stalled result changed")

    // The variance clamp never lets a zero variance out.
    `SBKE_ASSERT_SAME(a_var_floor, o_out_valid, o_bias_variance != 31'd0, "zero bias variance on output")

    // Only one transaction is in work at a time.
    `SBKE_ASSERT_NEXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall, "second transaction taken while busy")

endmodule

bind scalar_bias_kalman_estimator sbke_checker u_checker (.*);
